### sv/abna_pkg.sv
// ============================================================================
// abna_pkg
// Pixel type and fixed constants shared by the alpha bleed filter modules.
// ============================================================================
package abna_pkg;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd4096;

    // multiply-shift pair for an exact floor(s / 3) on s <= 765
    localparam logic [9:0] RECIP3 = 10'd683;
    localparam int RECIP3_SHIFT = 11;

    typedef struct packed {
        logic       opaque;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

endpackage

### sv/abna_avg.sv
// ============================================================================
// abna_avg
// Floor average of the opaque neighbors among up, left and up-left.
// ============================================================================
module abna_avg (
    input  abna_pkg::t_pixel i_up,
    input  abna_pkg::t_pixel i_left,
    input  abna_pkg::t_pixel i_ul,
    input  logic             i_use_up,
    input  logic             i_use_left,
    input  logic             i_use_ul,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);
    import abna_pkg::*;

    logic       w_up;
    logic       w_left;
    logic       w_ul;
    logic [1:0] w_count;

    function automatic logic [7:0] f_avg(input logic [9:0] s, input logic [1:0] n);
        logic [19:0] prod;
        logic [7:0]  q;
        prod = 20'(s) * 20'(RECIP3);
        case (n)
            2'd1:    q = s[7:0];
            2'd2:    q = s[8:1];
            2'd3:    q = 8'(prod >> RECIP3_SHIFT);
            default: q = 8'd0;
        endcase
        return q;
    endfunction

    function automatic logic [9:0] f_sum(input logic [7:0] a, input logic ea,
                                         input logic [7:0] b, input logic eb,
                                         input logic [7:0] c, input logic ec);
        return (ea ? 10'(a) : 10'd0) + (eb ? 10'(b) : 10'd0) + (ec ? 10'(c) : 10'd0);
    endfunction

    assign w_up    = i_use_up && i_up.opaque;
    assign w_left  = i_use_left && i_left.opaque;
    assign w_ul    = i_use_ul && i_ul.opaque;
    assign w_count = 2'(w_up) + 2'(w_left) + 2'(w_ul);

    assign o_red   = f_avg(f_sum(i_up.red, w_up, i_left.red, w_left, i_ul.red, w_ul), w_count);
    assign o_green = f_avg(f_sum(i_up.green, w_up, i_left.green, w_left,
                                 i_ul.green, w_ul), w_count);
    assign o_blue  = f_avg(f_sum(i_up.blue, w_up, i_left.blue, w_left,
                                 i_ul.blue, w_ul), w_count);

endmodule

### sv/alpha_bleed_neighbor_average.sv
// ============================================================================
// alpha_bleed_neighbor_average
// Fills transparent pixels with the average of their opaque original
// neighbors at up, left and up-left, using a one-row store in block memory.
// ============================================================================
// The input word is registered at accept and the result word is registered in
// the S_CALC state that follows; it is held until the receiver takes it.
// A new pixel is taken only in S_IDLE with the result slot free, set by the row
// store read-modify-write (read at accept, write back in the compute cycle).
// Reset: synchronous, active low; clears control state and sets the width to
// 4096. The row store is not cleared; row 0 never reads it.
module alpha_bleed_neighbor_average #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [abna_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_frame_start,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    input  logic [7:0]                i_alpha,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_out_red,
    output logic [7:0]                o_out_green,
    output logic [7:0]                o_out_blue,
    output logic [7:0]                o_out_alpha
);
    import abna_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (((AW + 1) > CFG_W) ? (AW + 1) : CFG_W) + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    t_pixel          r_mem [MAX_WIDTH];
    t_pixel          r_rdata;

    logic [CFG_W-1:0] r_width;
    logic             r_state;
    logic [AW-1:0]    r_col;
    logic             r_first;
    logic [AW-1:0]    r_icol;
    logic             r_ifirst;
    t_pixel           r_cur;
    logic [7:0]       r_alpha;
    t_pixel           r_left;
    t_pixel           r_ul;
    logic             r_out_valid;
    logic [7:0]       r_out_red;
    logic [7:0]       r_out_green;
    logic [7:0]       r_out_blue;
    logic [7:0]       r_out_alpha;

    logic             w_acc;
    logic [AW-1:0]    w_col;
    logic             w_first;
    t_pixel           w_up;
    logic             w_not_col0;
    logic [7:0]       w_avg_red;
    logic [7:0]       w_avg_green;
    logic [7:0]       w_avg_blue;
    logic [CW-1:0]    w_cfg;
    logic [CW-1:0]    w_eff;
    logic [CW-1:0]    w_next;

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_acc   = i_valid && o_ready;
    assign w_col   = i_frame_start ? '0 : r_col;
    assign w_first = i_frame_start || r_first;

    assign w_up       = r_ifirst ? t_pixel'('0) : r_rdata;
    assign w_not_col0 = (r_icol != '0);

    assign w_cfg  = {{(CW-CFG_W){1'b0}}, r_width};
    assign w_eff  = (w_cfg == '0) ? CW'(1) :
                    (w_cfg > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_cfg;
    assign w_next = {{(CW-AW){1'b0}}, r_icol} + CW'(1);

    abna_avg u_avg (
        .i_up       (w_up),
        .i_left     (r_left),
        .i_ul       (r_ul),
        .i_use_up   (!r_ifirst),
        .i_use_left (w_not_col0),
        .i_use_ul   (!r_ifirst && w_not_col0),
        .o_red      (w_avg_red),
        .o_green    (w_avg_green),
        .o_blue     (w_avg_blue)
    );

    // row store: read the up neighbor at accept, write the pixel back in S_CALC
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rdata <= r_mem[w_col];
        end
        if (r_state == S_CALC) begin
            r_mem[r_icol] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    if (w_next >= w_eff) begin
                        r_col   <= '0;
                        r_first <= 1'b0;
                    end else begin
                        r_col   <= w_next[AW-1:0];
                        r_first <= r_ifirst;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_icol       <= w_col;
            r_ifirst     <= w_first;
            r_cur.opaque <= (i_alpha != 8'd0);
            r_cur.red    <= i_red;
            r_cur.green  <= i_green;
            r_cur.blue   <= i_blue;
            r_alpha      <= i_alpha;
        end
        if (r_state == S_CALC) begin
            r_left <= r_cur;
            r_ul   <= w_up;
            if (r_cur.opaque) begin
                r_out_red   <= r_cur.red;
                r_out_green <= r_cur.green;
                r_out_blue  <= r_cur.blue;
                r_out_alpha <= r_alpha;
            end else begin
                r_out_red   <= w_avg_red;
                r_out_green <= w_avg_green;
                r_out_blue  <= w_avg_blue;
                r_out_alpha <= 8'd0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;

endmodule

### sv/abna_checker.sv
// ============================================================================
// abna_checker
// Port-level timing and alpha checks for the alpha bleed filter.
// ============================================================================
module abna_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_alpha,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_alpha
);

    logic w_acc;
    assign w_acc = i_valid && o_ready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_alpha)))
        else $error("result word dropped or changed while stalled");

    // one word in flight: no accept on the next edge
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !o_ready)
        else $error("input accepted while a word is in flight");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> ##1 o_valid)
        else $error("result word not shown two cycles after accept");

    a_opaque_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_alpha != 8'd0)) |=> ##1 (o_out_alpha == $past(i_alpha, 2)))
        else $error("opaque pixel alpha not passed through");

    a_filled_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_alpha == 8'd0)) |=> ##1 (o_out_alpha == 8'd0))
        else $error("filled pixel alpha not zero");

endmodule

bind alpha_bleed_neighbor_average abna_checker u_abna_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_alpha     (i_alpha),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_alpha (o_out_alpha)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Streams RGBA pixel words through the alpha bleed filter: a directed table
// covering image edges, frame restarts and width changes, then random images
// at a range of widths under varied flow control. Every result word is
// checked against the table's expected word or an in-bench model of the neighbor fill.
// ============================================================================
module testbench;
    import abna_pkg::*;

    localparam int MAX_COLS     = 4096;
    localparam int PHASES       = 10;
    localparam int PHASE_PIXELS = 195;
    localparam int DIR_ROWS     = 24;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    typedef enum logic {STEP_PIX, STEP_CFG} t_step_kind;

    typedef struct packed {
        t_step_kind       kind;
        logic [CFG_W-1:0] cfg;
        logic             fs;
        t_rgba            px;
        logic             typed;
        t_rgba            want;
    } t_step;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_valid = 1'b0;
    logic             i_frame_start = 1'b0;
    logic [7:0]       i_red = '0;
    logic [7:0]       i_green = '0;
    logic [7:0]       i_blue = '0;
    logic [7:0]       i_alpha = '0;
    logic             i_ready = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [7:0]       o_out_red;
    logic [7:0]       o_out_green;
    logic [7:0]       o_out_blue;
    logic [7:0]       o_out_alpha;

    alpha_bleed_neighbor_average u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_frame_start (i_frame_start),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_alpha       (i_alpha),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha)
    );

    always #4 i_clk = ~i_clk;

    // model state: previous row, left and up-left neighbors, position
    t_pixel           row_mem [MAX_COLS];
    t_pixel           left_px = '0;
    t_pixel           upleft_px = '0;
    logic [11:0]      col_cnt = '0;
    logic             first_row = 1'b1;
    logic [CFG_W-1:0] width_reg = WIDTH_RESET;

    t_rgba pending_q [$];
    t_rgba seen_px;
    t_rgba want_px;
    int    send_idle = 37;
    int    recv_idle = 83;
    int    errors = 0;
    int    results = 0;
    int    pixels = 0;
    int    fills = 0;

    int phase_width [PHASES] = '{5, 8191, 1, 4096, 2, 33, 0, 7, 12, 3};

    // pixel words are RRGGBBAA
    t_step dir_tab [DIR_ROWS] = '{
        // first pixel after reset, no frame start: no neighbors
        '{STEP_PIX, 13'd0, 1'b0, 32'hFFFFFF00, 1'b1, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'hFF0080FF, 1'b1, 32'hFF0080FF},
        '{STEP_PIX, 13'd0, 1'b0, 32'h12345600, 1'b0, 32'h00000000},
        '{STEP_CFG, 13'd3, 1'b0, 32'h00000000, 1'b0, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b1, 32'h00000001, 1'b1, 32'h00000001},
        '{STEP_PIX, 13'd0, 1'b0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{STEP_PIX, 13'd0, 1'b0, 32'h10203080, 1'b1, 32'h10203080},
        '{STEP_PIX, 13'd0, 1'b0, 32'hABCDEF00, 1'b0, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'h00000000, 1'b0, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'hFEFDFC7F, 1'b1, 32'hFEFDFC7F},
        '{STEP_PIX, 13'd0, 1'b0, 32'h00000000, 1'b0, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'h00000000, 1'b0, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'h00000000, 1'b0, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'h010203FF, 1'b1, 32'h010203FF},
        '{STEP_PIX, 13'd0, 1'b0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{STEP_PIX, 13'd0, 1'b0, 32'h80808040, 1'b1, 32'h80808040},
        '{STEP_PIX, 13'd0, 1'b0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        // all three neighbors opaque
        '{STEP_PIX, 13'd0, 1'b0, 32'h55555500, 1'b0, 32'h00000000},
        // frame start in the middle of a row
        '{STEP_PIX, 13'd0, 1'b1, 32'h99999900, 1'b1, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'hAA55AA01, 1'b1, 32'hAA55AA01},
        // shrink mid-image, zero acts as one; column already past the width
        '{STEP_CFG, 13'd0, 1'b0, 32'h00000000, 1'b0, 32'h00000000},
        '{STEP_PIX, 13'd0, 1'b0, 32'h123456FF, 1'b1, 32'h123456FF},
        '{STEP_PIX, 13'd0, 1'b0, 32'h778899FF, 1'b1, 32'h778899FF},
        '{STEP_PIX, 13'd0, 1'b0, 32'h00000000, 1'b0, 32'h00000000}
    };

    function automatic t_rgba bleed_predict(input logic fs, input t_rgba px);
        logic [CFG_W-1:0] span;
        logic [11:0]      col;
        t_pixel           up;
        t_pixel           cur;
        logic [9:0]       sr;
        logic [9:0]       sg;
        logic [9:0]       sb;
        logic [1:0]       n;
        t_rgba            res;
        if (width_reg == '0) begin
            span = CFG_W'(1);
        end else if (width_reg > CFG_W'(MAX_COLS)) begin
            span = CFG_W'(MAX_COLS);
        end else begin
            span = width_reg;
        end
        if (fs) begin
            col_cnt = '0;
            first_row = 1'b1;
        end
        col = col_cnt;
        up = first_row ? '0 : row_mem[col];
        sr = '0;
        sg = '0;
        sb = '0;
        n = '0;
        if (!first_row && up.opaque) begin
            sr += up.red;
            sg += up.green;
            sb += up.blue;
            n = n + 2'd1;
        end
        if (col != 0) begin
            if (left_px.opaque) begin
                sr += left_px.red;
                sg += left_px.green;
                sb += left_px.blue;
                n = n + 2'd1;
            end
            if (!first_row && upleft_px.opaque) begin
                sr += upleft_px.red;
                sg += upleft_px.green;
                sb += upleft_px.blue;
                n = n + 2'd1;
            end
        end
        if (px.a != 0) begin
            res = px;
        end else begin
            res.a = '0;
            res.r = (n == 0) ? 8'd0 : 8'(sr / n);
            res.g = (n == 0) ? 8'd0 : 8'(sg / n);
            res.b = (n == 0) ? 8'd0 : 8'(sb / n);
        end
        // neighbors always come from the original input, not the fill
        cur = '{opaque: (px.a != 0), red: px.r, green: px.g, blue: px.b};
        upleft_px = up;
        left_px = cur;
        row_mem[col] = cur;
        if ({1'b0, col} + 13'd1 >= span) begin
            col_cnt = '0;
            first_row = 1'b0;
        end else begin
            col_cnt = col + 12'd1;
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endtask

    // entered and left at a falling edge
    task automatic drive_pixel(input t_step st);
        t_rgba guess;
        if ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_valid <= 1'b1;
        i_frame_start <= st.fs;
        i_red <= st.px.r;
        i_green <= st.px.g;
        i_blue <= st.px.b;
        i_alpha <= st.px.a;
        do @(posedge i_clk); while (!o_ready);
        guess = bleed_predict(st.fs, st.px);
        pending_q.push_back(st.typed ? st.want : guess);
        pixels++;
        if (st.px.a == 0) begin
            fills++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        width_reg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results++;
            seen_px = {o_out_red, o_out_green, o_out_blue, o_out_alpha};
            if (pending_q.size() == 0) begin
                flag_error($sformatf("result word %0d with nothing pending: %h",
                                     results, seen_px));
            end else begin
                want_px = pending_q.pop_front();
                if (seen_px.r !== want_px.r || seen_px.g !== want_px.g ||
                    seen_px.b !== want_px.b || seen_px.a !== want_px.a) begin
                    flag_error($sformatf("result word %0d: expected rgba %h got %h",
                                         results, want_px, seen_px));
                end
            end
        end
    end

    initial begin
        t_step st;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == STEP_CFG) begin
                write_width(dir_tab[i].cfg);
            end else begin
                drive_pixel(dir_tab[i]);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 4) begin
                send_idle = 83;
                recv_idle = 37;
            end else if (ph == 7) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_width(CFG_W'(phase_width[ph]));
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                // hold off until the pipeline is empty
                if (k == PHASE_PIXELS / 2) begin
                    drain_results();
                end
                st = '0;
                st.kind = STEP_PIX;
                st.fs = (k == 0) || ($urandom_range(0, 199) == 0);
                st.px.r = 8'($urandom_range(0, 255));
                st.px.g = 8'($urandom_range(0, 255));
                st.px.b = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: st.px.a = 8'd0;
                    4: st.px.a = 8'd255;
                    5: st.px.a = 8'd1;
                    default: st.px.a = 8'($urandom_range(1, 255));
                endcase
                drive_pixel(st);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            flag_error($sformatf("%0d expected words never arrived", pending_q.size()));
        end
        $display("Sent %0d pixel words (%0d transparent) over %0d widths incl. 0 and 8191,",
                 pixels, fills, PHASES + 3);
        $display("checked %0d result words, %0d mismatches.", results, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d words still pending", pending_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
